// ===== src/tefd_pkg.sv =====
package tefd_pkg;

  // event decode
  localparam logic [4:0] EVT_SYN        = 5'd0;
  localparam logic [4:0] EVT_KEY        = 5'd1;
  localparam logic [4:0] EVT_ABS        = 5'd3;
  localparam logic [9:0] CODE_REPORT    = 10'h000;
  localparam logic [9:0] CODE_BTN_TOUCH = 10'h14A;
  localparam logic [9:0] CODE_POS_X     = 10'h035;
  localparam logic [9:0] CODE_POS_Y     = 10'h036;
  localparam logic [31:0] BTN_UP        = 32'h0;
  localparam logic [31:0] BTN_DOWN      = 32'h1;

  // result status
  localparam logic [1:0] STATUS_DOWN = 2'd0;
  localparam logic [1:0] STATUS_MOVE = 2'd1;
  localparam logic [1:0] STATUS_UP   = 2'd2;

  // rotation codes
  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  // register indexes
  localparam logic [2:0] REG_ROTATION    = 3'd0;
  localparam logic [2:0] REG_DISP_WIDTH  = 3'd1;
  localparam logic [2:0] REG_DISP_HEIGHT = 3'd2;
  localparam logic [2:0] REG_TOUCH_MAX_X = 3'd3;
  localparam logic [2:0] REG_TOUCH_MAX_Y = 3'd4;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // register reset values
  localparam logic [1:0]  RST_ROTATION    = 2'd0;
  localparam logic [13:0] RST_DISP_WIDTH  = 14'd1080;
  localparam logic [13:0] RST_DISP_HEIGHT = 14'd2400;
  localparam logic [15:0] RST_TOUCH_MAX   = 16'd4095;

  // quotient bits produced by the divider
  localparam int DIV_STEPS = 16;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic ev_fire;
    logic mul_en;
    logic abs_en;
    logic div_init;
    logic div_step;
    logic sat_en;
    logic sel_y;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_report;
  } sts_t;

endpackage

// ===== src/tefd_ctrl.sv =====
module tefd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  tefd_pkg::sts_t sts_i,
  output tefd_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ABS,
    ST_INIT,
    ST_DIV,
    ST_SAT,
    ST_OUT
  } state_e;

  state_e state_q;
  logic   sel_y_q;
  logic   out_valid_q;
  logic [tefd_pkg::DIV_CNT_W-1:0] cnt_q;

  logic in_fire;
  logic out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.ev_fire  = in_fire;
    cmd_o.mul_en   = (state_q == ST_MUL);
    cmd_o.abs_en   = (state_q == ST_ABS);
    cmd_o.div_init = (state_q == ST_INIT);
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.sat_en   = (state_q == ST_SAT);
    cmd_o.sel_y    = sel_y_q;
    cmd_o.out_load = (state_q == ST_OUT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sel_y_q     <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire && sts_i.is_report) begin
            sel_y_q <= 1'b0;
            state_q <= ST_MUL;
          end
        end
        ST_MUL:  state_q <= ST_ABS;
        ST_ABS:  state_q <= ST_INIT;
        ST_INIT: begin
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == tefd_pkg::DIV_CNT_W'(tefd_pkg::DIV_STEPS - 1)) begin
            state_q <= ST_SAT;
          end
        end
        ST_SAT: begin
          if (sel_y_q) begin
            state_q <= ST_OUT;
          end else begin
            sel_y_q <= 1'b1;
            state_q <= ST_MUL;
          end
        end
        ST_OUT: begin
          // hold until the output register is free
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== src/tefd_dp.sv =====
module tefd_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tefd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tefd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [4:0]                        req_type_i,
  input  logic [9:0]                        ev_code_i,
  input  logic signed [31:0]                ev_value_i,
  input  tefd_pkg::cmd_t                    cmd_i,
  output tefd_pkg::sts_t                    sts_o,
  output logic [1:0]                        touch_status_o,
  output logic signed [15:0]                point_x_o,
  output logic signed [15:0]                point_y_o
);

  // configuration
  logic [1:0]  rotation_q;
  logic [13:0] disp_w_q;
  logic [13:0] disp_h_q;
  logic [15:0] tmax_x_q;
  logic [15:0] tmax_y_q;

  // event state
  logic signed [31:0] last_x_q;
  logic signed [31:0] last_y_q;
  logic               btn_seen_q;
  logic               pressed_q;
  logic [1:0]         status_q;

  // arithmetic
  logic signed [48:0] prod_q;
  logic signed [48:0] prod_d;
  logic [47:0]        mag_q;
  logic [48:0]        mag_full;
  logic               neg_q;
  logic               ovf_q;
  logic [15:0]        rem_q;
  logic [15:0]        quo_q;
  logic [15:0]        xs_q;
  logic [15:0]        ys_q;

  logic [1:0]         touch_status_q;
  logic [15:0]        point_x_q;
  logic [15:0]        point_y_q;

  logic signed [33:0] sx, sy, mx, my, rx, ry;
  logic signed [33:0] mul_a;
  logic signed [14:0] mul_b;
  logic [15:0]        range_sel;
  logic [15:0]        div_sel;
  logic [16:0]        trial;
  logic               trial_ge;
  logic [16:0]        trial_sub;
  logic [15:0]        sat_res;

  assign sts_o.is_report = (req_type_i == tefd_pkg::EVT_SYN)
                        && (ev_code_i == tefd_pkg::CODE_REPORT)
                        && (ev_value_i == 32'sd0);

  // rotate the kept point
  always_comb begin
    sx = {{2{last_x_q[31]}}, last_x_q};
    sy = {{2{last_y_q[31]}}, last_y_q};
    mx = {18'd0, tmax_x_q};
    my = {18'd0, tmax_y_q};
    case (rotation_q)
      tefd_pkg::ROT_90: begin
        rx = sy;
        ry = mx - sx;
      end
      tefd_pkg::ROT_180: begin
        rx = mx - sx;
        ry = my - sy;
      end
      tefd_pkg::ROT_270: begin
        rx = my - sy;
        ry = sx;
      end
      default: begin
        rx = sx;
        ry = sy;
      end
    endcase
    mul_a     = cmd_i.sel_y ? ry : rx;
    mul_b     = cmd_i.sel_y ? $signed({1'b0, disp_h_q}) : $signed({1'b0, disp_w_q});
    prod_d    = mul_a * mul_b;
    range_sel = cmd_i.sel_y ? tmax_y_q : tmax_x_q;
    div_sel   = (range_sel == 16'd0) ? 16'd1 : range_sel;
  end

  assign mag_full = prod_q[48] ? ((~prod_q) + 49'd1) : prod_q;

  // one restoring step: shift in the next dividend bit
  assign trial     = {rem_q, quo_q[15]};
  assign trial_ge  = (trial >= {1'b0, div_sel});
  assign trial_sub = trial - {1'b0, div_sel};

  always_comb begin
    if (ovf_q) begin
      sat_res = neg_q ? 16'h8000 : 16'h7FFF;
    end else if (!neg_q) begin
      sat_res = quo_q[15] ? 16'h7FFF : quo_q;
    end else if (quo_q > 16'h8000) begin
      sat_res = 16'h8000;
    end else begin
      sat_res = (~quo_q) + 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotation_q <= tefd_pkg::RST_ROTATION;
      disp_w_q   <= tefd_pkg::RST_DISP_WIDTH;
      disp_h_q   <= tefd_pkg::RST_DISP_HEIGHT;
      tmax_x_q   <= tefd_pkg::RST_TOUCH_MAX;
      tmax_y_q   <= tefd_pkg::RST_TOUCH_MAX;
      last_x_q   <= '0;
      last_y_q   <= '0;
      btn_seen_q <= 1'b0;
      pressed_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tefd_pkg::REG_ROTATION:    rotation_q <= cfg_data_i[1:0];
          tefd_pkg::REG_DISP_WIDTH:  disp_w_q   <= cfg_data_i[13:0];
          tefd_pkg::REG_DISP_HEIGHT: disp_h_q   <= cfg_data_i[13:0];
          tefd_pkg::REG_TOUCH_MAX_X: tmax_x_q   <= cfg_data_i;
          tefd_pkg::REG_TOUCH_MAX_Y: tmax_y_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.ev_fire) begin
        if (req_type_i == tefd_pkg::EVT_ABS) begin
          if (ev_code_i == tefd_pkg::CODE_POS_X) begin
            last_x_q <= ev_value_i;
          end else if (ev_code_i == tefd_pkg::CODE_POS_Y) begin
            last_y_q <= ev_value_i;
          end
        end else if (req_type_i == tefd_pkg::EVT_KEY) begin
          if (ev_code_i == tefd_pkg::CODE_BTN_TOUCH &&
              (ev_value_i == tefd_pkg::BTN_UP || ev_value_i == tefd_pkg::BTN_DOWN)) begin
            btn_seen_q <= 1'b1;
            pressed_q  <= ev_value_i[0];
          end
        end else if (sts_o.is_report) begin
          // latch frame status, clear marks for the next frame
          btn_seen_q <= 1'b0;
          pressed_q  <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ev_fire && sts_o.is_report) begin
      status_q <= !btn_seen_q ? tefd_pkg::STATUS_MOVE :
                  (pressed_q ? tefd_pkg::STATUS_DOWN : tefd_pkg::STATUS_UP);
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.abs_en) begin
      neg_q <= prod_q[48];
      mag_q <= mag_full[47:0];
    end
    if (cmd_i.div_init) begin
      // quotient reaches 2^16 exactly when the upper part is not below the divisor
      ovf_q <= (mag_q[47:16] >= {16'd0, div_sel});
      rem_q <= mag_q[31:16];
      quo_q <= mag_q[15:0];
    end
    if (cmd_i.div_step) begin
      rem_q <= trial_ge ? trial_sub[15:0] : trial[15:0];
      quo_q <= {quo_q[14:0], trial_ge};
    end
    if (cmd_i.sat_en) begin
      if (cmd_i.sel_y) begin
        ys_q <= sat_res;
      end else begin
        xs_q <= sat_res;
      end
    end
    if (cmd_i.out_load) begin
      touch_status_q <= status_q;
      point_x_q      <= xs_q;
      point_y_q      <= ys_q;
    end
  end

  assign touch_status_o = touch_status_q;
  assign point_x_o      = $signed(point_x_q);
  assign point_y_o      = $signed(point_y_q);

endmodule

// ===== src/touch_event_frame_decoder.sv =====
// Touch event frame decoder.
// Input channel (in_valid_i/in_ready_o) carries one input event word: type,
// code and signed value. Position and touch-button words update internal
// state and are taken one per cycle, back to back. A sync report word
// (type sync, code report, value 0) closes the frame and starts the
// coordinate pipeline; no further word is taken until it is done.
// Each coordinate runs multiply (one 34x15 signed multiplier, shared),
// magnitude, overflow check and a 16-step restoring divider, then
// saturation, X then Y. A result is loaded into the output register
// once both axes are done, and the input is ready again in the cycle
// after the load; any other word is taken without leaving idle.
// Output channel (out_valid_o/out_ready_i) holds status and point until
// taken. When the receiver stalls, new words are still taken; a following
// report computes its result and then waits for the output register to free.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at once.
// Reset clears the kept position and frame marks and loads the default
// registers; the output channel comes up empty.
module touch_event_frame_decoder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tefd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tefd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [4:0]                      req_type_i,
  input  logic [9:0]                      ev_code_i,
  input  logic signed [31:0]              ev_value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [1:0]                      touch_status_o,
  output logic signed [15:0]              point_x_o,
  output logic signed [15:0]              point_y_o
);

  tefd_pkg::cmd_t cmd;
  tefd_pkg::sts_t sts;

  tefd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tefd_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .req_type_i     (req_type_i),
    .ev_code_i      (ev_code_i),
    .ev_value_i     (ev_value_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .touch_status_o (touch_status_o),
    .point_x_o      (point_x_o),
    .point_y_o      (point_y_o)
  );

  // a report word starts the compute sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && sts.is_report) |=> !in_ready_o)
    else $error("input still ready after report word");

  // a fresh result appears only as the sequencer returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result loaded while still busy");

  // status code is always one of down, move, up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (touch_status_o == tefd_pkg::STATUS_DOWN ||
                     touch_status_o == tefd_pkg::STATUS_MOVE ||
                     touch_status_o == tefd_pkg::STATUS_UP))
    else $error("invalid touch status");

  // the output register is only reloaded once it is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || out_ready_i))
    else $error("output overwritten while stalled");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tefd_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES = 400;
  localparam int WORDS_PER_SEGMENT = 165;
  localparam int NUM_SEGMENTS = 8;

  typedef struct packed {
    logic [4:0]         kind;
    logic [9:0]         code;
    logic signed [31:0] value;
  } ev_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } touch_pt_t;

  class touch_scoreboard;
    logic [1:0]  rot;
    logic [13:0] disp_w;
    logic [13:0] disp_h;
    logic [15:0] max_x;
    logic [15:0] max_y;
    longint      last_x;
    longint      last_y;
    bit          btn_seen;
    bit          pressed;
    touch_pt_t   due_points[$];
    int          mismatches;

    function new();
      rot = RST_ROTATION;
      disp_w = RST_DISP_WIDTH;
      disp_h = RST_DISP_HEIGHT;
      max_x = RST_TOUCH_MAX;
      max_y = RST_TOUCH_MAX;
      last_x = 0;
      last_y = 0;
      btn_seen = 1'b0;
      pressed = 1'b0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_ROTATION:    rot = data[1:0];
        REG_DISP_WIDTH:  disp_w = data[13:0];
        REG_DISP_HEIGHT: disp_h = data[13:0];
        REG_TOUCH_MAX_X: max_x = data;
        REG_TOUCH_MAX_Y: max_y = data;
        default: ;
      endcase
    endfunction

    // exact product, quotient truncated toward zero, then clamp to 16 bits
    function logic signed [15:0] scale_axis(longint p, longint mul, longint range);
      longint d;
      longint q;
      d = (range == 0) ? 1 : range;
      q = (p * mul) / d;
      if (q > 32767) q = 32767;
      else if (q < -32768) q = -32768;
      return q[15:0];
    endfunction

    function void note_word(ev_word_t w);
      longint    v;
      longint    rx;
      longint    ry;
      longint    mx;
      longint    my;
      touch_pt_t pt;
      v = longint'(w.value);
      mx = longint'(max_x);
      my = longint'(max_y);
      if (w.kind == EVT_ABS) begin
        if (w.code == CODE_POS_X) last_x = v;
        else if (w.code == CODE_POS_Y) last_y = v;
      end else if (w.kind == EVT_KEY) begin
        if (w.code == CODE_BTN_TOUCH && (w.value == BTN_UP || w.value == BTN_DOWN)) begin
          btn_seen = 1'b1;
          pressed = (w.value == BTN_DOWN);
        end
      end else if (w.kind == EVT_SYN && w.code == CODE_REPORT && w.value == 0) begin
        case (rot)
          ROT_90: begin
            rx = last_y;
            ry = mx - last_x;
          end
          ROT_180: begin
            rx = mx - last_x;
            ry = my - last_y;
          end
          ROT_270: begin
            rx = my - last_y;
            ry = last_x;
          end
          default: begin
            rx = last_x;
            ry = last_y;
          end
        endcase
        if (!btn_seen) pt.status = STATUS_MOVE;
        else pt.status = pressed ? STATUS_DOWN : STATUS_UP;
        pt.x = scale_axis(rx, longint'(disp_w), mx);
        pt.y = scale_axis(ry, longint'(disp_h), my);
        due_points = {due_points, pt};
        btn_seen = 1'b0;
        pressed = 1'b0;
      end
    endfunction

    function void check_result(touch_pt_t got);
      touch_pt_t want;
      if (due_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected point: status %0d x %0d y %0d", got.status, got.x, got.y);
        return;
      end
      want = due_points.pop_front();
      if (got.status !== want.status || got.x !== want.x || got.y !== want.y) begin
        mismatches++;
        if (mismatches <= 10)
          $display("point mismatch: expected status %0d x %0d y %0d, got status %0d x %0d y %0d",
                   want.status, want.x, want.y, got.status, got.x, got.y);
      end
    endfunction

    function int pending_count();
      return due_points.size();
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [4:0]            req_type_i = '0;
  logic [9:0]            ev_code_i = '0;
  logic signed [31:0]    ev_value_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [1:0]            touch_status_o;
  logic signed [15:0]    point_x_o;
  logic signed [15:0]    point_y_o;

  touch_scoreboard sb = new();
  int  send_idle_pct = 23;
  int  recv_idle_pct = 63;
  logic hold_off = 1'b0;
  int  cycle_cnt = 0;

  touch_event_frame_decoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .ev_code_i      (ev_code_i),
    .ev_value_i     (ev_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .touch_status_o (touch_status_o),
    .point_x_o      (point_x_o),
    .point_y_o      (point_y_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    while (cycle_cnt < LIMIT_CYCLES) @(posedge clk_i);
    $display("status: fail");
    $finish;
  end

  // receiver: take points, stall at random or during a hold-off
  initial begin
    touch_pt_t got;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got.status = touch_status_o;
        got.x = point_x_o;
        got.y = point_y_o;
        sb.check_result(got);
      end
      out_ready_i <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic ev_word_t make_word(logic [4:0] kind, logic [9:0] code,
                                         logic signed [31:0] value);
    ev_word_t w;
    w.kind = kind;
    w.code = code;
    w.value = value;
    return w;
  endfunction

  task automatic push_word(ev_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= w.kind;
    ev_code_i <= w.code;
    ev_value_i <= w.value;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_word(w);
  endtask

  // drop valid, wait for every point, then let the pipeline go quiet
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(int seg);
    logic [15:0] junk;
    junk = 16'($urandom());
    case (seg)
      0: begin
        write_reg(REG_ROTATION, {junk[15:2], ROT_90});
        write_reg(REG_DISP_WIDTH, 16'd8192);
        write_reg(REG_DISP_HEIGHT, 16'd8192);
        write_reg(REG_TOUCH_MAX_X, 16'd1);
        write_reg(REG_TOUCH_MAX_Y, 16'd1);
      end
      1: begin
        write_reg(REG_ROTATION, {junk[15:2], ROT_180});
        write_reg(REG_DISP_WIDTH, 16'd1);
        write_reg(REG_DISP_HEIGHT, 16'd1);
        write_reg(REG_TOUCH_MAX_X, 16'hFFFF);
        write_reg(REG_TOUCH_MAX_Y, 16'hFFFF);
      end
      2: begin
        // zero ranges fall back to a divisor of one; upper data bits drop
        write_reg(REG_ROTATION, {junk[15:2], ROT_270});
        write_reg(REG_DISP_WIDTH, 16'hC000);
        write_reg(REG_DISP_HEIGHT, 16'hFFFF);
        write_reg(REG_TOUCH_MAX_X, 16'd0);
        write_reg(REG_TOUCH_MAX_Y, 16'd0);
      end
      3: begin
        write_reg(REG_ROTATION, {junk[15:2], ROT_0});
        write_reg(REG_DISP_WIDTH, 16'(RST_DISP_WIDTH));
        write_reg(REG_DISP_HEIGHT, 16'(RST_DISP_HEIGHT));
        write_reg(REG_TOUCH_MAX_X, RST_TOUCH_MAX);
        write_reg(REG_TOUCH_MAX_Y, RST_TOUCH_MAX);
      end
      default: begin
        write_reg(REG_ROTATION, junk);
        write_reg(REG_DISP_WIDTH, 16'($urandom_range(8192, 1)));
        write_reg(REG_DISP_HEIGHT, 16'($urandom_range(8192, 1)));
        write_reg(REG_TOUCH_MAX_X, 16'($urandom_range(65535, 1)));
        write_reg(REG_TOUCH_MAX_Y, 16'($urandom_range(65535, 1)));
      end
    endcase
    write_reg(REG_TOUCH_MAX_Y + 3'($urandom_range(3, 1)), 16'($urandom()));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] pick_coord(logic [15:0] lim);
    case ($urandom_range(9))
      0: return 32'sd0;
      1: return {16'h0, lim};
      2: return 32'($urandom());
      3: return 32'sd0 - 32'($urandom_range(100, 1));
      4: return {16'h0, lim} + 32'($urandom_range(100, 1));
      default: return 32'($urandom_range(lim));
    endcase
  endfunction

  function automatic logic signed [31:0] pick_button();
    case ($urandom_range(7))
      6: return 32'sd2;
      7: return 32'($urandom());
      default: return $urandom_range(1) ? BTN_DOWN : BTN_UP;
    endcase
  endfunction

  function automatic ev_word_t pick_noise();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(5))
      0: return make_word(5'($urandom_range(31)), 10'($urandom_range(767)), v);
      1: return make_word(EVT_SYN, CODE_REPORT, (v == 0) ? 32'sd1 : v);
      2: return make_word(EVT_SYN, 10'($urandom_range(767, 1)), 32'sd0);
      3: return make_word(EVT_ABS, 10'($urandom_range(767)), v);
      4: return make_word(EVT_KEY, 10'($urandom_range(767)), BTN_DOWN);
      default: return make_word(5'($urandom_range(31, 4)), 10'($urandom_range(767)), v);
    endcase
  endfunction

  // mostly whole frames with random content, some cut short, some noise
  task automatic run_traffic(int target);
    int n;
    int k;
    int buttons;
    n = 0;
    while (n < target) begin
      k = $urandom_range(99);
      if (k < 90) begin
        if ($urandom_range(3) != 0) begin
          push_word(make_word(EVT_ABS, CODE_POS_X, pick_coord(sb.max_x)));
          n++;
        end
        if ($urandom_range(3) != 0) begin
          push_word(make_word(EVT_ABS, CODE_POS_Y, pick_coord(sb.max_y)));
          n++;
        end
        if ($urandom_range(9) == 0) begin
          push_word(pick_noise());
          n++;
        end
        buttons = $urandom_range(3);
        repeat (buttons) begin
          push_word(make_word(EVT_KEY, CODE_BTN_TOUCH, pick_button()));
          n++;
        end
        if (k < 80) begin
          push_word(make_word(EVT_SYN, CODE_REPORT, 32'sd0));
          n++;
        end
      end else begin
        push_word(pick_noise());
        n++;
      end
    end
  endtask

  task automatic hold_receiver();
    repeat ($urandom_range(80, 20)) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed frames at the reset settings
    push_word(make_word(EVT_ABS, CODE_POS_X, 32'sd0));
    push_word(make_word(EVT_ABS, CODE_POS_Y, 32'sd0));
    push_word(make_word(EVT_SYN, CODE_REPORT, 32'sd0));
    push_word(make_word(EVT_ABS, CODE_POS_X, 32'sd4095));
    push_word(make_word(EVT_ABS, CODE_POS_Y, 32'sd4095));
    push_word(make_word(EVT_KEY, CODE_BTN_TOUCH, BTN_DOWN));
    push_word(make_word(EVT_SYN, CODE_REPORT, 32'sd0));
    // last button word in a frame wins
    push_word(make_word(EVT_KEY, CODE_BTN_TOUCH, BTN_DOWN));
    push_word(make_word(EVT_KEY, CODE_BTN_TOUCH, BTN_UP));
    push_word(make_word(EVT_SYN, CODE_REPORT, 32'sd0));
    push_word(make_word(EVT_KEY, CODE_BTN_TOUCH, 32'sd2));
    push_word(make_word(EVT_SYN, CODE_REPORT, 32'sd0));
    push_word(make_word(EVT_SYN, CODE_REPORT, 32'sd1));
    push_word(make_word(EVT_SYN, CODE_REPORT + 10'd1, 32'sd0));
    push_word(make_word(EVT_ABS - 5'd1, CODE_POS_X, 32'sd7));
    push_word(make_word(5'd31, 10'd767, -32'sd1));
    push_word(make_word(EVT_ABS, CODE_POS_Y + 10'd1, 32'sd99));
    push_word(make_word(EVT_ABS, CODE_POS_X, 32'sh7FFF_FFFF));
    push_word(make_word(EVT_ABS, CODE_POS_Y, 32'sh8000_0000));
    push_word(make_word(EVT_KEY, CODE_BTN_TOUCH, BTN_UP));
    push_word(make_word(EVT_SYN, CODE_REPORT, 32'sd0));
    push_word(make_word(EVT_ABS, CODE_POS_X, -32'sd1));
    push_word(make_word(EVT_SYN, CODE_REPORT, 32'sd0));
    drain();

    for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
      if (seg < 3) begin
        send_idle_pct = 23;
        recv_idle_pct = 63;
      end else if (seg < 6) begin
        send_idle_pct = 63;
        recv_idle_pct = 23;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      configure(seg);
      if (seg == 1 || seg == 6) begin
        fork
          run_traffic(WORDS_PER_SEGMENT);
          hold_receiver();
        join
      end else begin
        run_traffic(WORDS_PER_SEGMENT);
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.pending_count() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
